// ===== src/fpfa_pkg.sv =====
// Types and constants for the fixed partition fit allocator core.
`timescale 1ns / 1ps

package fpfa_pkg;

  localparam int MODE_W     = 2;
  localparam int SLOT_W     = 5;
  localparam int AMOUNT_W   = 16;
  localparam int LEFTOVER_W = 16;
  localparam int FREE_W     = 21;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam int COUNT_W    = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIT_POLICY = 1'b0,
    CFG_PART_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_PLACE = 2'd1,
    MODE_FREE  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [SLOT_W-1:0]   slot;
    logic [AMOUNT_W-1:0] amount;
  } in_t;

  typedef struct packed {
    logic                  granted;
    logic [SLOT_W-1:0]     chosen_slot;
    logic [LEFTOVER_W-1:0] leftover;
    logic [FREE_W-1:0]     free_total;
  } out_t;

endpackage

// ===== src/fpfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fpfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/fixed_partition_fit_allocator_core.sv =====
// Top level of the fixed partition allocator: first fit / best fit over a size table.
// Each transaction runs a scan over the n active partitions, then a finishing state that
//   registers the result strobe; busy holds off a new transaction until the block is idle.
// The scan reads one partition size per cycle from the single read port of the size RAM
//   into one shared compare/subtract unit.
// Reset (rst_ni low, asynchronous): clear used marks, fit_policy, partition_count, state.
// Partition sizes are not cleared and must be loaded before they take part in a scan.
// Results are strobed for one cycle on out_valid_o; the receiver cannot stall.
`timescale 1ns / 1ps

module fixed_partition_fit_allocator_core #(
  parameter int PARTITIONS = 32,
  parameter int SIZE_BITS  = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  fpfa_pkg::in_t                      in_i,
  output logic                               out_valid_o,
  output fpfa_pkg::out_t                     out_o,
  input  logic                               cfg_we_i,
  input  logic [fpfa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fpfa_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  import fpfa_pkg::*;

  localparam int IdxW     = $clog2(PARTITIONS);
  localparam int CntW     = $clog2(PARTITIONS + 1);
  localparam int SW       = SIZE_BITS;
  localparam int AmtExtW  = (SW > AMOUNT_W) ? SW : AMOUNT_W;
  localparam int SumExtW  = (SW > FREE_W) ? SW : FREE_W;
  localparam int LeftExtW = (SW > LEFTOVER_W) ? SW : LEFTOVER_W;
  localparam int SlotExtW = (IdxW > SLOT_W) ? IdxW : SLOT_W;

  // Configuration registers
  logic               fit_policy_q;
  logic [COUNT_W-1:0] part_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_policy_q <= 1'b0;
      part_count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FIT_POLICY: fit_policy_q <= cfg_data_i[0];
        CFG_PART_COUNT: part_count_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers
  state_e                state_q, state_d;
  logic [CntW-1:0]       iss_q, iss_d;       // next address to read
  logic [CntW-1:0]       n_q, n_d;           // active partitions for this transaction
  logic                  pv_q, pv_d;         // read data valid this cycle
  logic [IdxW-1:0]       pidx_q, pidx_d;     // index of the read data
  logic [MODE_W-1:0]     mode_q, mode_d;
  logic [SW-1:0]         req_q, req_d;
  logic [FREE_W-1:0]     acc_q, acc_d;
  logic                  found_q, found_d;
  logic [IdxW-1:0]       pick_q, pick_d;
  logic [SW-1:0]         best_q, best_d;
  logic [SW-1:0]         pick_size_q, pick_size_d;
  logic [PARTITIONS-1:0] used_q, used_d;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q, out_d;

  // Input decode
  logic                  accept;
  logic [AmtExtW-1:0]    amt_ext;
  logic [SW-1:0]         amt_sz;
  logic [SlotExtW-1:0]   slot_ext;
  logic                  slot_ok;
  logic [CntW-1:0]       active_n;

  assign accept   = start && !busy;
  assign amt_ext  = AmtExtW'(in_i.amount);
  assign amt_sz   = amt_ext[SW-1:0];
  assign slot_ext = SlotExtW'(in_i.slot);
  assign slot_ok  = int'(in_i.slot) < PARTITIONS;
  assign active_n = (int'(part_count_q) > PARTITIONS) ? CntW'(PARTITIONS)
                                                      : CntW'(part_count_q);

  // Size table: written at accept for a load to a valid slot, read during the scan while addresses remain
  logic            ram_we;
  logic            ram_re;
  logic [SW-1:0]   ram_rdata;

  assign ram_we = accept && (mode_e'(in_i.mode) == MODE_LOAD) && slot_ok;

  fpfa_ram #(
    .WIDTH (SW),
    .DEPTH (PARTITIONS)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_ext[IdxW-1:0]),
    .wdata_i (amt_sz),
    .re_i    (ram_re),
    .raddr_i (iss_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Shared compare/subtract unit: one partition per cycle
  logic [SW:0]          diff;
  logic                 fits;
  logic                 is_free;
  logic                 better;
  logic [SumExtW-1:0]   sz_ext;
  logic [SumExtW-1:0]   pick_ext;
  logic [LeftExtW-1:0]  left_ext;
  logic [SlotExtW-1:0]  pick_slot_ext;
  logic                 grant;

  assign diff     = {1'b0, ram_rdata} - {1'b0, req_q};
  assign fits     = !diff[SW];
  assign is_free  = !used_q[pidx_q];
  assign better   = !found_q || (fit_policy_q && (diff[SW-1:0] < best_q));
  assign sz_ext   = SumExtW'(ram_rdata);
  assign pick_ext = SumExtW'(pick_size_q);
  assign left_ext = LeftExtW'(best_q);
  assign pick_slot_ext = SlotExtW'(pick_q);
  assign grant    = (mode_e'(mode_q) == MODE_PLACE) && found_q;

  always_comb begin
    state_d     = state_q;
    iss_d       = iss_q;
    n_d         = n_q;
    pv_d        = 1'b0;
    pidx_d      = pidx_q;
    mode_d      = mode_q;
    req_d       = req_q;
    acc_d       = acc_q;
    found_d     = found_q;
    pick_d      = pick_q;
    best_d      = best_q;
    pick_size_d = pick_size_q;
    used_d      = used_q;
    out_valid_d = 1'b0;
    out_d       = out_q;
    ram_re      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
          iss_d   = '0;
          n_d     = active_n;
          mode_d  = in_i.mode;
          req_d   = amt_sz;
          acc_d   = '0;
          found_d = 1'b0;
          pick_d  = '0;
          best_d  = '0;
          // Free all drops every mark before the scan sums the free sizes
          if (mode_e'(in_i.mode) == MODE_FREE) begin
            used_d = '0;
          end
        end
      end

      ST_SCAN: begin
        // Issue the next read while addresses remain
        if (iss_q < n_q) begin
          ram_re = 1'b1;
          pv_d   = 1'b1;
          pidx_d = iss_q[IdxW-1:0];
          iss_d  = iss_q + CntW'(1);
        end
        // Consume the read data of the previous cycle
        if (pv_q && is_free) begin
          acc_d = acc_q + sz_ext[FREE_W-1:0];
          if ((mode_e'(mode_q) == MODE_PLACE) && fits && better) begin
            found_d     = 1'b1;
            pick_d      = pidx_q;
            best_d      = diff[SW-1:0];
            pick_size_d = ram_rdata;
          end
        end
        if (!(iss_q < n_q) && !pv_q) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        state_d                = ST_IDLE;
        out_valid_d            = 1'b1;
        out_d.granted          = grant;
        out_d.chosen_slot      = grant ? pick_slot_ext[SLOT_W-1:0] : '0;
        out_d.leftover         = grant ? left_ext[LEFTOVER_W-1:0] : '0;
        // Take the granted partition out of the free sum
        out_d.free_total       = grant ? (acc_q - pick_ext[FREE_W-1:0]) : acc_q;
        if (grant) begin
          used_d[pick_q] = 1'b1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iss_q       <= '0;
      n_q         <= '0;
      pv_q        <= 1'b0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      iss_q       <= iss_d;
      n_q         <= n_d;
      pv_q        <= pv_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
    end
  end

  // Payload registers hold without reset
  always_ff @(posedge clk_i) begin
    pidx_q      <= pidx_d;
    mode_q      <= mode_d;
    req_q       <= req_d;
    acc_q       <= acc_d;
    pick_q      <= pick_d;
    best_q      <= best_d;
    pick_size_q <= pick_size_d;
    out_q       <= out_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // A result strobe follows only the finishing cycle of a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(state_q == ST_DONE))
    else $error("result strobe without a finished transaction");

  // The read address never runs past the active partition count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (iss_q <= n_q))
    else $error("scan address ran past the partition count");

  // Read data is only valid during a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> (state_q == ST_SCAN))
    else $error("read data valid outside a scan");

  // No grant reports a zero slot and a zero leftover
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_o.granted) |-> (out_o.chosen_slot == '0 && out_o.leftover == '0))
    else $error("refused request reports a slot or leftover");

endmodule
